/* sv/vwb_pkg.sv */
`default_nettype none
package vwb_pkg;

   // Field widths
   localparam int PIX_W     = 32;
   localparam int CH_W      = 8;
   localparam int N_CH      = 4;
   localparam int ROW_W     = 12;
   localparam int HEIGHT_W  = 13;
   localparam int POS_W     = 17;
   localparam int CSR_W     = 17;
   localparam int CSR_IDX_W = 1;

   // Derived datapath widths (band width is at most half the 13-bit height)
   localparam int BW_W      = HEIGHT_W - 1;
   localparam int SQ_W      = 2 * BW_W;
   localparam int IDX_W     = HEIGHT_W + 2;
   localparam int PROD_W    = HEIGHT_W + 1 + POS_W;
   localparam int NUM_W     = SQ_W + CH_W;
   localparam int FRAC_BITS = 16;

   localparam logic [POS_W-1:0]    POS_ONE        = POS_W'(65536);
   localparam logic [PROD_W-1:0]   ROUND_HALF     = PROD_W'(32768);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = HEIGHT_W'(480);
   localparam logic [POS_W-1:0]    POSITION_RESET = '0;

   // Divider: quotient bits per channel spread over the stages
   localparam int DIV_STAGES = 4;
   localparam int DIV_BITS   = CH_W / DIV_STAGES;

   // Cycles for the geometry pipeline to settle after a register write
   localparam int SETTLE_CYCLES = 4;
   localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_HEIGHT  = 1'b0,
      CSR_EDGE_POSITION = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_index;
      logic [PIX_W-1:0] pixel_a;
      logic [PIX_W-1:0] pixel_b;
   } req_type;

   typedef struct packed {
      logic signed [IDX_W-1:0] thresh;
      logic [BW_W-1:0]         bw;
      logic [BW_W-1:0]         half_bw;
      logic [SQ_W-1:0]         s;
      logic [SQ_W-1:0]         half_s;
   } geo_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_a;
      logic [PIX_W-1:0] pixel_b;
      logic             sel_a;
      logic             sel_b;
      logic [SQ_W-1:0]  k;
   } wgt_type;

endpackage
`default_nettype wire

/* sv/vwb_req_if.sv */
`default_nettype none
interface vwb_req_if;
   logic                         valid;
   logic                         ready;
   logic [vwb_pkg::ROW_W-1:0]    row_index;
   logic [vwb_pkg::PIX_W-1:0]    pixel_a;
   logic [vwb_pkg::PIX_W-1:0]    pixel_b;

   modport source (output valid, output row_index, output pixel_a, output pixel_b,
                   input ready);
   modport sink   (input valid, input row_index, input pixel_a, input pixel_b,
                   output ready);
endinterface
`default_nettype wire

/* sv/vwb_rsp_if.sv */
`default_nettype none
interface vwb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [vwb_pkg::PIX_W-1:0]    mixed_pixel;

   modport source (output valid, output mixed_pixel, input ready);
   modport sink   (input valid, input mixed_pixel, output ready);
endinterface
`default_nettype wire

/* sv/vertical_wipe_blend_top.sv */
`default_nettype none
// Bottom-to-top soft-edge wipe from pixel_a (outgoing) to pixel_b (incoming), RGBA8888.
// A band of frame_height/BAND_DIVISOR rows moves up as edge_position (Q1.16, 65536 =
// done) grows; rows above it pass pixel_a, rows below pass pixel_b, rows inside get each
// byte mixed with a quadratic ease weight and rounded. One item per clock sustained
// while neither side stalls; a result passes 4 weight stages, 2 product stages,
// 4 divider stages at 2 quotient bits each and 1 output register. Every stage holds under
// back-pressure and fills bubbles, so stalls on either side lose nothing. After reset
// and after each register write, req_port.ready stays low while the band geometry
// (band width, start row, divisor) is recomputed; write registers only while
// no item is in flight.
module vertical_wipe_blend_top #(
   parameter int unsigned BAND_DIVISOR = 16,
   parameter int unsigned MAX_HEIGHT   = 4096
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   vwb_req_if.sink                             req_port,
   vwb_rsp_if.source                           rsp_port,
   input  wire logic                           csr_we,
   input  wire logic [vwb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [vwb_pkg::CSR_W-1:0]      csr_wdata
);

   vwb_pkg::geo_type geo;
   logic             geo_settled;
   vwb_pkg::req_type req_data;
   logic             w_in_valid, w_in_ready;
   vwb_pkg::wgt_type w_out;
   logic             w_out_valid, w_out_ready;

   // Registers and per-frame band geometry
   vwb_geometry #(
      .BAND_DIVISOR (BAND_DIVISOR),
      .MAX_HEIGHT   (MAX_HEIGHT)
   ) u_geometry (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geo       (geo),
      .settled   (geo_settled)
   );

   // Hold off input while geometry settles
   assign req_data.row_index = req_port.row_index;
   assign req_data.pixel_a   = req_port.pixel_a;
   assign req_data.pixel_b   = req_port.pixel_b;
   assign w_in_valid         = req_port.valid && geo_settled;
   assign req_port.ready     = w_in_ready && geo_settled;

   // Band index, region select and blend weight
   vwb_weight u_weight (
      .clock     (clock),
      .reset     (reset),
      .geo       (geo),
      .in_valid  (w_in_valid),
      .in_ready  (w_in_ready),
      .in_data   (req_data),
      .out_valid (w_out_valid),
      .out_ready (w_out_ready),
      .out_data  (w_out)
   );

   // Per-channel mix and divide by the squared band width
   vwb_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .geo       (geo),
      .in_valid  (w_out_valid),
      .in_ready  (w_out_ready),
      .in_data   (w_out),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_pixel (rsp_port.mixed_pixel)
   );

`ifndef NO_ASSERTIONS
   // A register write must block input until the geometry is recomputed
   a_csr_blocks_input: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_port.ready)
      else $error("input accepted right after a register write");

   // Reset empties the pipeline
   a_reset_flushes: assert property (@(posedge clock)
      reset |=> !rsp_port.valid)
      else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

/* sv/vwb_geometry.sv */
`default_nettype none
module vwb_geometry #(
   parameter int unsigned BAND_DIVISOR = 16,
   parameter int unsigned MAX_HEIGHT   = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [vwb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [vwb_pkg::CSR_W-1:0]       csr_wdata,
   output vwb_pkg::geo_type                     geo,
   output logic                                 settled
);
   localparam int HEIGHT_W = vwb_pkg::HEIGHT_W;
   localparam int POS_W    = vwb_pkg::POS_W;
   localparam int BW_W     = vwb_pkg::BW_W;
   localparam int SQ_W     = vwb_pkg::SQ_W;
   localparam int IDX_W    = vwb_pkg::IDX_W;
   localparam int PROD_W   = vwb_pkg::PROD_W;

   // Band width by reciprocal multiply, exact for every 13-bit height
   localparam int              BW_SHIFT  = HEIGHT_W + $clog2(BAND_DIVISOR);
   localparam int              BW_PROD_W = HEIGHT_W + BW_SHIFT + 1;
   localparam longint unsigned BW_RECIP  =
      ((longint'(1) << BW_SHIFT) + BAND_DIVISOR - 1) / BAND_DIVISOR;

   logic [HEIGHT_W-1:0]         height_ff;
   logic [POS_W-1:0]            position_ff;
   logic [vwb_pkg::SETTLE_W-1:0] settle_ff;

   logic [HEIGHT_W-1:0] h1_ff, h1_in, h2_ff, h3_ff;
   logic [POS_W-1:0]    p1_ff, p1_in, p2_ff;
   logic [BW_W-1:0]     bw2_ff, bw3_ff;
   logic [PROD_W-1:0]   prod3_ff;
   logic [SQ_W-1:0]     s3_ff;
   logic [HEIGHT_W:0]   sum2;
   logic [PROD_W-1:0]   rnd_sum;
   logic [BW_PROD_W-1:0] bw_prod;
   vwb_pkg::geo_type    geo_ff, geo_in;

   // Register file; reload the settle counter on every write
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff   <= vwb_pkg::HEIGHT_RESET;
         position_ff <= vwb_pkg::POSITION_RESET;
         settle_ff   <= vwb_pkg::SETTLE_W'(vwb_pkg::SETTLE_CYCLES);
      end else begin
         if (csr_we) begin
            case (csr_index)
               vwb_pkg::CSR_FRAME_HEIGHT:  height_ff   <= csr_wdata[HEIGHT_W-1:0];
               vwb_pkg::CSR_EDGE_POSITION: position_ff <= csr_wdata[POS_W-1:0];
               default: ;
            endcase
            settle_ff <= vwb_pkg::SETTLE_W'(vwb_pkg::SETTLE_CYCLES);
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - 1'b1;
         end
      end
   end

   // Clamp height and position
   always_comb begin
      h1_in = height_ff;
      if (height_ff == '0) begin
         h1_in = HEIGHT_W'(1);
      end else if ({1'b0, height_ff} > (HEIGHT_W+1)'(MAX_HEIGHT)) begin
         h1_in = HEIGHT_W'(MAX_HEIGHT);
      end
      p1_in = (position_ff > vwb_pkg::POS_ONE) ? vwb_pkg::POS_ONE : position_ff;
   end

   assign bw_prod = BW_PROD_W'(h1_ff) * BW_PROD_W'(BW_RECIP);
   assign sum2    = {1'b0, h2_ff} + {2'b00, bw2_ff};
   assign rnd_sum = prod3_ff + vwb_pkg::ROUND_HALF;

   // Start row of the band and the blend divisor
   always_comb begin
      geo_in.thresh  = $signed({(IDX_W-HEIGHT_W)'(0), h3_ff})
                     - $signed(IDX_W'(rnd_sum[PROD_W-1:vwb_pkg::FRAC_BITS]));
      geo_in.bw      = bw3_ff;
      geo_in.half_bw = bw3_ff >> 1;
      geo_in.s       = s3_ff;
      geo_in.half_s  = s3_ff >> 1;
   end

   always_ff @(posedge clock) begin
      h1_ff    <= h1_in;
      p1_ff    <= p1_in;
      h2_ff    <= h1_ff;
      p2_ff    <= p1_ff;
      bw2_ff   <= bw_prod[BW_SHIFT +: BW_W];
      h3_ff    <= h2_ff;
      bw3_ff   <= bw2_ff;
      prod3_ff <= PROD_W'(sum2) * PROD_W'(p2_ff);
      s3_ff    <= SQ_W'(bw2_ff) * SQ_W'(bw2_ff);
      geo_ff   <= geo_in;
   end

   assign geo     = geo_ff;
   assign settled = (settle_ff == '0);

endmodule
`default_nettype wire

/* sv/vwb_weight.sv */
`default_nettype none
module vwb_weight (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire vwb_pkg::geo_type geo,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire vwb_pkg::req_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output vwb_pkg::wgt_type      out_data
);
   localparam int PIX_W = vwb_pkg::PIX_W;
   localparam int BW_W  = vwb_pkg::BW_W;
   localparam int SQ_W  = vwb_pkg::SQ_W;
   localparam int IDX_W = vwb_pkg::IDX_W;
   localparam int ROW_W = vwb_pkg::ROW_W;
   localparam int N_ST  = 4;

   typedef struct packed {
      logic [PIX_W-1:0]        pixel_a;
      logic [PIX_W-1:0]        pixel_b;
      logic signed [IDX_W-1:0] idx;
   } idx_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_a;
      logic [PIX_W-1:0] pixel_b;
      logic             sel_a;
      logic             sel_b;
      logic             lower;
      logic [BW_W-1:0]  span;
   } cls_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_a;
      logic [PIX_W-1:0] pixel_b;
      logic             sel_a;
      logic             sel_b;
      logic             lower;
      logic [SQ_W-1:0]  sq;
   } sq_type;

   logic [N_ST-1:0] v_ff;
   logic [N_ST:0]   ld;
   idx_type          idx_ff, idx_in;
   cls_type          cls_ff, cls_in;
   sq_type           sq_ff, sq_in;
   vwb_pkg::wgt_type wgt_ff, wgt_in;
   logic [BW_W-1:0]  row_off;
   logic [SQ_W:0]    twice;
   logic [SQ_W+1:0]  diff;

   // A stage takes new data when empty or when its content moves on
   assign ld[N_ST] = out_ready;
   for (genvar g = 0; g < N_ST; g++) begin : g_ld
      assign ld[g] = !v_ff[g] || ld[g+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < N_ST; s++) begin
            if (ld[s]) begin
               v_ff[s] <= (s == 0) ? in_valid : v_ff[(s == 0) ? 0 : s-1];
            end
         end
      end
   end

   // Row position relative to the band
   always_comb begin
      idx_in.pixel_a = in_data.pixel_a;
      idx_in.pixel_b = in_data.pixel_b;
      idx_in.idx     = $signed({(IDX_W-ROW_W)'(0), in_data.row_index}) - geo.thresh;
   end

   // Classify, fold distance onto the nearer band edge
   assign row_off = idx_ff.idx[BW_W-1:0];
   always_comb begin
      cls_in.pixel_a = idx_ff.pixel_a;
      cls_in.pixel_b = idx_ff.pixel_b;
      cls_in.sel_a   = idx_ff.idx[IDX_W-1];
      cls_in.sel_b   = !idx_ff.idx[IDX_W-1]
                     && (idx_ff.idx >= $signed({(IDX_W-BW_W)'(0), geo.bw}));
      cls_in.lower   = row_off < geo.half_bw;
      cls_in.span    = cls_in.lower ? row_off : geo.bw - row_off;
   end

   always_comb begin
      sq_in.pixel_a = cls_ff.pixel_a;
      sq_in.pixel_b = cls_ff.pixel_b;
      sq_in.sel_a   = cls_ff.sel_a;
      sq_in.sel_b   = cls_ff.sel_b;
      sq_in.lower   = cls_ff.lower;
      sq_in.sq      = SQ_W'(cls_ff.span) * SQ_W'(cls_ff.span);
   end

   // Weight; upper half clamps at zero for a one-row band
   assign twice = {sq_ff.sq, 1'b0};
   assign diff  = {2'b00, geo.s} - {1'b0, twice};
   always_comb begin
      wgt_in.pixel_a = sq_ff.pixel_a;
      wgt_in.pixel_b = sq_ff.pixel_b;
      wgt_in.sel_a   = sq_ff.sel_a;
      wgt_in.sel_b   = sq_ff.sel_b;
      if (sq_ff.lower) begin
         wgt_in.k = twice[SQ_W-1:0];
      end else if (diff[SQ_W+1]) begin
         wgt_in.k = '0;
      end else begin
         wgt_in.k = diff[SQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) idx_ff <= idx_in;
      if (ld[1]) cls_ff <= cls_in;
      if (ld[2]) sq_ff  <= sq_in;
      if (ld[3]) wgt_ff <= wgt_in;
   end

   assign in_ready  = ld[0];
   assign out_valid = v_ff[N_ST-1];
   assign out_data  = wgt_ff;

endmodule
`default_nettype wire

/* sv/vwb_blend.sv */
`default_nettype none
module vwb_blend (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire vwb_pkg::geo_type             geo,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire vwb_pkg::wgt_type             in_data,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic [vwb_pkg::PIX_W-1:0]         out_pixel
);
   localparam int PIX_W      = vwb_pkg::PIX_W;
   localparam int CH_W       = vwb_pkg::CH_W;
   localparam int N_CH       = vwb_pkg::N_CH;
   localparam int NUM_W      = vwb_pkg::NUM_W;
   localparam int DIV_STAGES = vwb_pkg::DIV_STAGES;
   localparam int DIV_BITS   = vwb_pkg::DIV_BITS;
   localparam int N_ST       = DIV_STAGES + 3;

   typedef struct packed {
      logic [PIX_W-1:0]            pixel_a;
      logic [PIX_W-1:0]            pixel_b;
      logic                        sel_a;
      logic                        sel_b;
      logic [N_CH-1:0][NUM_W-1:0]  part_a;
      logic [N_CH-1:0][NUM_W-1:0]  part_b;
   } prod_type;

   typedef struct packed {
      logic [PIX_W-1:0]            pixel_a;
      logic [PIX_W-1:0]            pixel_b;
      logic                        sel_a;
      logic                        sel_b;
      logic [N_CH-1:0][NUM_W-1:0]  rem;
      logic [N_CH-1:0][CH_W-1:0]   quo;
   } div_type;

   logic [N_ST-1:0]  v_ff;
   logic [N_ST:0]    ld;
   prod_type         prod_ff, prod_in;
   div_type          div_ff [DIV_STAGES+1];
   div_type          div_in [DIV_STAGES+1];
   logic [PIX_W-1:0] out_ff, out_in;

   assign ld[N_ST] = out_ready;
   for (genvar g = 0; g < N_ST; g++) begin : g_ld
      assign ld[g] = !v_ff[g] || ld[g+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < N_ST; s++) begin
            if (ld[s]) begin
               v_ff[s] <= (s == 0) ? in_valid : v_ff[(s == 0) ? 0 : s-1];
            end
         end
      end
   end

   // Partial products a*(S-k) and b*k per channel
   always_comb begin
      prod_in.pixel_a = in_data.pixel_a;
      prod_in.pixel_b = in_data.pixel_b;
      prod_in.sel_a   = in_data.sel_a;
      prod_in.sel_b   = in_data.sel_b;
      for (int ch = 0; ch < N_CH; ch++) begin
         prod_in.part_a[ch] = NUM_W'(in_data.pixel_a[ch*CH_W +: CH_W])
                            * NUM_W'(geo.s - in_data.k);
         prod_in.part_b[ch] = NUM_W'(in_data.pixel_b[ch*CH_W +: CH_W])
                            * NUM_W'(in_data.k);
      end
   end

   // Rounded numerator, then restoring division by S, DIV_BITS bits a stage
   always_comb begin
      div_in[0].pixel_a = prod_ff.pixel_a;
      div_in[0].pixel_b = prod_ff.pixel_b;
      div_in[0].sel_a   = prod_ff.sel_a;
      div_in[0].sel_b   = prod_ff.sel_b;
      div_in[0].quo     = '0;
      for (int ch = 0; ch < N_CH; ch++) begin
         div_in[0].rem[ch] = prod_ff.part_a[ch] + prod_ff.part_b[ch]
                           + NUM_W'(geo.half_s);
      end
      for (int j = 0; j < DIV_STAGES; j++) begin
         div_in[j+1] = div_ff[j];
         for (int st = 0; st < DIV_BITS; st++) begin
            for (int ch = 0; ch < N_CH; ch++) begin
               if (div_in[j+1].rem[ch] >= (NUM_W'(geo.s) << (CH_W-1 - j*DIV_BITS - st))) begin
                  div_in[j+1].rem[ch] = div_in[j+1].rem[ch]
                                      - (NUM_W'(geo.s) << (CH_W-1 - j*DIV_BITS - st));
                  div_in[j+1].quo[ch][CH_W-1 - j*DIV_BITS - st] = 1'b1;
               end
            end
         end
      end
   end

   // Pick a source pixel outside the band, the quotient inside it
   always_comb begin
      if (div_ff[DIV_STAGES].sel_a) begin
         out_in = div_ff[DIV_STAGES].pixel_a;
      end else if (div_ff[DIV_STAGES].sel_b) begin
         out_in = div_ff[DIV_STAGES].pixel_b;
      end else begin
         out_in = div_ff[DIV_STAGES].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) prod_ff <= prod_in;
      for (int j = 0; j <= DIV_STAGES; j++) begin
         if (ld[j+1]) div_ff[j] <= div_in[j];
      end
      if (ld[N_ST-1]) out_ff <= out_in;
   end

   assign in_ready  = ld[0];
   assign out_valid = v_ff[N_ST-1];
   assign out_pixel = out_ff;

endmodule
`default_nettype wire

/* sim/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Geometry constants of the instance under test
   localparam int     BAND_DIV     = 16;
   localparam int     MAX_ROWS     = 4096;
   localparam longint ONE_Q16      = 65536;
   localparam longint HALF_Q16     = 32768;
   localparam int     ROW_MAX      = 4095;
   localparam int     PIPE_LATENCY = 11;
   localparam int     CYCLE_LIMIT  = 200000;
   localparam int     MAX_PRINTS   = 40;

   localparam logic [vwb_pkg::ROW_W-1:0] FIRST_ROW = '0;
   localparam logic [vwb_pkg::ROW_W-1:0] LAST_ROW  = '1;

   typedef struct {
      logic [vwb_pkg::ROW_W-1:0] row;
      logic [vwb_pkg::PIX_W-1:0] mix;
   } mix_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vwb_req_if req_bus ();
   vwb_rsp_if rsp_bus ();

   logic                         csr_we;
   vwb_pkg::csr_index_type       csr_index;
   logic [vwb_pkg::CSR_W-1:0]    csr_wdata;

   // Testbench copy of the two wipe registers, updated on every write
   logic [vwb_pkg::HEIGHT_W-1:0] wipe_height   = vwb_pkg::HEIGHT_RESET;
   logic [vwb_pkg::POS_W-1:0]    wipe_position = vwb_pkg::POSITION_RESET;

   // Mixed pixels still owed by the block, oldest first
   mix_entry_type expected_mix[$];
   int unsigned   mismatch_count = 0;

   // Idle knobs, changed per phase by the test tasks
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_off_left  = 0;

   vertical_wipe_blend_top #(
      .BAND_DIVISOR (BAND_DIV),
      .MAX_HEIGHT   (MAX_ROWS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Wipe predictor
   // ------------------------------------------------------------------

   // Band width and the first band row for the current register copy.
   // Clamp height to 1..MAX_ROWS and position to 1.0 first.
   function automatic void band_geometry(output longint bw, output longint top);
      longint h, p, off;
      h = longint'(wipe_height);
      p = longint'(wipe_position);
      if (h < 1) h = 1;
      if (h > MAX_ROWS) h = MAX_ROWS;
      if (p > ONE_Q16) p = ONE_Q16;
      bw  = h / BAND_DIV;
      // offset rounds half up in Q0.16
      off = (((h + bw) * p + HALF_Q16) >>> vwb_pkg::FRAC_BITS) - bw;
      top = h - off - bw;
   endfunction

   function automatic logic [vwb_pkg::PIX_W-1:0] wipe_mix(
      input logic [vwb_pkg::ROW_W-1:0] row,
      input logic [vwb_pkg::PIX_W-1:0] pa,
      input logic [vwb_pkg::PIX_W-1:0] pb);
      longint bw, top, i, s, k, ca, cb, v;
      logic [vwb_pkg::PIX_W-1:0] mix;
      band_geometry(bw, top);
      i = longint'(row) - top;
      // above the band: outgoing source; below or no band: incoming source
      if (i < 0) return pa;
      if (i >= bw) return pb;
      s = bw * bw;
      // quadratic ease in, then ease out past the band middle
      if (i < bw / 2) k = 2 * i * i;
      else            k = s - 2 * (bw - i) * (bw - i);
      // a one-row band would go negative here: hold it at zero
      if (k < 0) k = 0;
      if (k > s) k = s;
      mix = '0;
      for (int ch = 0; ch < vwb_pkg::N_CH; ch++) begin
         ca = longint'(pa[ch*vwb_pkg::CH_W +: vwb_pkg::CH_W]);
         cb = longint'(pb[ch*vwb_pkg::CH_W +: vwb_pkg::CH_W]);
         v  = (ca * (s - k) + cb * k + s / 2) / s;
         mix[ch*vwb_pkg::CH_W +: vwb_pkg::CH_W] = vwb_pkg::CH_W'(v);
      end
      return mix;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Row at a given distance from the first band row, kept inside the field
   function automatic logic [vwb_pkg::ROW_W-1:0] band_row(input longint offset);
      longint bw, top, r;
      band_geometry(bw, top);
      r = top + offset;
      if (r < 0) r = 0;
      if (r > ROW_MAX) r = ROW_MAX;
      return vwb_pkg::ROW_W'(r);
   endfunction

   // Mostly rows in and around the band, the rest anywhere
   function automatic logic [vwb_pkg::ROW_W-1:0] pick_row();
      longint bw, top;
      band_geometry(bw, top);
      if ($urandom_range(0, 9) < 3) return vwb_pkg::ROW_W'($urandom_range(0, ROW_MAX));
      return band_row(longint'($urandom_range(0, int'(bw) + 3)) - 2);
   endfunction

   function automatic logic [vwb_pkg::PIX_W-1:0] random_pixel();
      logic [vwb_pkg::PIX_W-1:0] px;
      px = $urandom();
      // push some channels to their rails
      for (int ch = 0; ch < vwb_pkg::N_CH; ch++) begin
         case ($urandom_range(0, 7))
            0: px[ch*vwb_pkg::CH_W +: vwb_pkg::CH_W] = '0;
            1: px[ch*vwb_pkg::CH_W +: vwb_pkg::CH_W] = '1;
            default: ;
         endcase
      end
      return px;
   endfunction

   function automatic logic [vwb_pkg::HEIGHT_W-1:0] pick_height();
      case ($urandom_range(0, 9))
         // zero or one-row band
         0: return vwb_pkg::HEIGHT_W'($urandom_range(0, 2 * BAND_DIV - 1));
         // near, at and past the cap
         1: return vwb_pkg::HEIGHT_W'($urandom_range(MAX_ROWS - 6, 8191));
         2: return vwb_pkg::HEIGHT_W'($urandom_range(1, 8191));
         default: return vwb_pkg::HEIGHT_W'($urandom_range(2 * BAND_DIV, 1200));
      endcase
   endfunction

   function automatic logic [vwb_pkg::POS_W-1:0] pick_position();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return vwb_pkg::POS_W'(ONE_Q16);
         2: return vwb_pkg::POS_W'($urandom_range(ONE_Q16 + 1, 131071));  // saturates
         default: return vwb_pkg::POS_W'($urandom_range(0, ONE_Q16));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Driving tasks
   // ------------------------------------------------------------------

   // Offer one pixel pair, idling first at the phase's rate, and hold it
   // until the block takes it. Record the expected mix at offer time: the
   // registers cannot change before it is taken.
   task automatic send_pixel(input logic [vwb_pkg::ROW_W-1:0] row,
                             input logic [vwb_pkg::PIX_W-1:0] pa,
                             input logic [vwb_pkg::PIX_W-1:0] pb);
      int unsigned   gap;
      mix_entry_type entry;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct && gap < 12) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.row_index <= row;
      req_bus.pixel_a   <= pa;
      req_bus.pixel_b   <= pb;
      entry.row = row;
      entry.mix = wipe_mix(row, pa, pb);
      expected_mix.push_back(entry);
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Drop valid and hold until every owed item has come back
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (expected_mix.size() != 0) @(posedge clock);
   endtask

   // Write both wipe registers once the block is empty
   task automatic set_wipe(input logic [vwb_pkg::HEIGHT_W-1:0] height,
                           input logic [vwb_pkg::POS_W-1:0]    position);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_index <= vwb_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= vwb_pkg::CSR_W'(height);
      @(posedge clock);
      csr_index <= vwb_pkg::CSR_EDGE_POSITION;
      csr_wdata <= vwb_pkg::CSR_W'(position);
      @(posedge clock);
      csr_we        <= 1'b0;
      wipe_height    = height;
      wipe_position  = position;
   endtask

   // ------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what,
                                  input logic [vwb_pkg::ROW_W-1:0] row,
                                  input logic [vwb_pkg::PIX_W-1:0] got,
                                  input logic [vwb_pkg::PIX_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("%0t: %s, row %0d: mixed_pixel %08h, expected %08h",
                  $time, what, row, got, want);
   endtask

   // Receiver: a long hold-off when requested, else random stalls
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_off_left  = hold_off_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Compare each taken item with the oldest expectation
   always @(posedge clock) begin
      mix_entry_type entry;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_mix.size() == 0) begin
            report_mismatch("item with none expected", '0, rsp_bus.mixed_pixel, 'x);
         end else begin
            entry = expected_mix.pop_front();
            if (rsp_bus.mixed_pixel !== entry.mix)
               report_mismatch("wrong mix", entry.row, rsp_bus.mixed_pixel, entry.mix);
         end
      end
   end

   // Watchdog: end the run if it hangs
   initial begin : watchdog
      int unsigned cycles_run;
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset registers: 480 rows, position zero, band sits just below the frame
   task automatic test_reset_defaults();
      send_pixel(FIRST_ROW,    32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(band_row(-1), 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(band_row(0),  32'hFFFF_FFFF, 32'h0000_0000);  // weight zero
      send_pixel(band_row(1),  32'h0000_0000, 32'hFFFF_FFFF);
      send_pixel(band_row(14), 32'h00FF_00FF, 32'hFF00_FF00);
      send_pixel(band_row(15), 32'hFF00_FF00, 32'h00FF_00FF);  // second half of band
      send_pixel(band_row(29), 32'h0000_0000, 32'hFFFF_FFFF);
      send_pixel(band_row(30), 32'h1234_5678, 32'h9ABC_DEF0);  // past the band
      send_pixel(LAST_ROW,     32'h0000_0000, 32'hFFFF_FFFF);
   endtask

   task automatic test_special_cases();
      // zero height behaves as one row, no band
      set_wipe('0, vwb_pkg::POS_W'(HALF_Q16));
      send_pixel(FIRST_ROW,              32'hA5A5_A5A5, 32'h5A5A_5A5A);
      send_pixel(vwb_pkg::ROW_W'(1),     32'hA5A5_A5A5, 32'h5A5A_5A5A);
      send_pixel(LAST_ROW,               32'hA5A5_A5A5, 32'h5A5A_5A5A);
      // height just under the divisor: still no band
      set_wipe(vwb_pkg::HEIGHT_W'(BAND_DIV - 1), vwb_pkg::POS_W'(ONE_Q16 - 1));
      send_pixel(band_row(-1), 32'h0000_0000, 32'hFFFF_FFFF);
      send_pixel(band_row(0),  32'h0000_0000, 32'hFFFF_FFFF);
      // one-row band: its row keeps the outgoing pixel
      set_wipe(vwb_pkg::HEIGHT_W'(BAND_DIV + 1), vwb_pkg::POS_W'(HALF_Q16));
      send_pixel(band_row(-1), 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(band_row(0),  32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(band_row(1),  32'hFFFF_FFFF, 32'h0000_0000);
      // height and position both at their field maximum, past the caps: fully wiped
      set_wipe('1, '1);
      send_pixel(FIRST_ROW, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(LAST_ROW,  32'hFFFF_FFFF, 32'h0000_0000);
      // widest band, half way: walk its edges and middle
      set_wipe(vwb_pkg::HEIGHT_W'(MAX_ROWS), vwb_pkg::POS_W'(HALF_Q16));
      send_pixel(band_row(0),   32'h0000_0000, 32'hFFFF_FFFF);
      send_pixel(band_row(127), 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(band_row(128), 32'h00FF_FF00, 32'hFF00_00FF);
      send_pixel(band_row(255), 32'h0000_0000, 32'hFFFF_FFFF);
      // exactly done
      set_wipe(vwb_pkg::HEIGHT_W'(1000), vwb_pkg::POS_W'(ONE_Q16));
      send_pixel(FIRST_ROW, 32'hFFFF_FFFF, 32'h0000_0000);
   endtask

   // Random registers and pixels under one idle pattern
   task automatic test_random_wipes(input int unsigned idle_pct,
                                    input int unsigned stall_pct,
                                    input int          settings,
                                    input int          per_setting);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (settings) begin
         set_wipe(pick_height(), pick_position());
         repeat (per_setting) send_pixel(pick_row(), random_pixel(), random_pixel());
      end
   endtask

   // Fill the pipe against a held-off receiver, pause until empty, then run with random stalls
   task automatic test_backpressure();
      set_wipe(vwb_pkg::HEIGHT_W'(MAX_ROWS), vwb_pkg::POS_W'(HALF_Q16));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_left  = 80;
      repeat (40) send_pixel(pick_row(), random_pixel(), random_pixel());
      wait_for_results();
      recv_stall_pct = 46;
      repeat (20) send_pixel(pick_row(), random_pixel(), random_pixel());
   endtask

   initial begin
      // known values on every input before the first edge
      req_bus.valid     = 1'b0;
      req_bus.row_index = '0;
      req_bus.pixel_a   = '0;
      req_bus.pixel_b   = '0;
      rsp_bus.ready     = 1'b0;
      csr_we            = 1'b0;
      csr_index         = vwb_pkg::CSR_FRAME_HEIGHT;
      csr_wdata         = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_special_cases();
      test_random_wipes(0,  0,  4, 36);
      test_random_wipes(46, 0,  4, 36);
      test_random_wipes(0,  46, 4, 36);
      test_random_wipes(25, 25, 4, 36);
      test_backpressure();

      // drain, then give stray items time to show up
      wait_for_results();
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
